FILE: sv/fpa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the frame period averager and frame rate counter.
// Used by fpa_history, fpa_divider and frame_period_averager_fps_counter.

package fpa_pkg;

    // Number of frame periods kept in the moving-average window.
    localparam int HISTORY_DEPTH = 16;

    // Field widths.
    localparam int TS_W     = 64;
    localparam int PERIOD_W = 32;
    localparam int RATE_W   = 16;

    // Widths that follow from the window depth.
    localparam int HIST_AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W   = PERIOD_W + $clog2(HISTORY_DEPTH);
    localparam int WTICK_W = PERIOD_W + 1;

    // Reset value of the ticks-per-second register.
    localparam logic [PERIOD_W-1:0] TICK_FREQ_RESET = 32'd10_000_000;

    // Event kinds.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // Input item: one timestamp event.
    typedef struct packed {
        logic            kind;
        logic [TS_W-1:0] timestamp;
    } evt_item_t;

    // Result item: latched frame rate and current mean period.
    typedef struct packed {
        logic [RATE_W-1:0]   frame_rate;
        logic [PERIOD_W-1:0] average_ticks;
    } res_item_t;

    // Request to the serial divider.
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

endpackage

FILE: sv/fpa_history.sv
`timescale 1ns / 1ps
// Ring buffer memory holding the accepted frame periods of the averaging window.
// Depends on fpa_pkg for the depth and widths.

module fpa_history (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [fpa_pkg::HIST_AW-1:0]           wr_addr,
    input  logic [fpa_pkg::PERIOD_W-1:0]          wr_data,
    input  logic [fpa_pkg::HIST_AW-1:0]           rd_addr,
    output logic [fpa_pkg::PERIOD_W-1:0]          rd_data
);

    logic [fpa_pkg::PERIOD_W-1:0] mem [fpa_pkg::HISTORY_DEPTH];
    logic [fpa_pkg::PERIOD_W-1:0] rd_data_reg;

    // One write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // One registered read port.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/fpa_divider.sv
`timescale 1ns / 1ps
// Restoring serial divider: window sum over sample count, one quotient bit a cycle.
// Depends on fpa_pkg for widths and the request struct.

module fpa_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fpa_pkg::div_req_t             req,
    output logic                          done,
    output logic [fpa_pkg::PERIOD_W-1:0]  quotient
);

    localparam int STEP_W = $clog2(fpa_pkg::SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(fpa_pkg::SUM_W - 1);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic [fpa_pkg::CNT_W-1:0]   rem_reg, rem_next;
    logic [fpa_pkg::SUM_W-1:0]   quo_reg, quo_next;
    logic [fpa_pkg::CNT_W-1:0]   divisor_reg, divisor_next;
    logic [fpa_pkg::CNT_W:0]     shifted;
    logic [fpa_pkg::CNT_W:0]     trial;
    logic                        qbit;

    // Shift in the next dividend bit and try a subtraction.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[fpa_pkg::SUM_W-1]};
        trial   = shifted - {1'b0, divisor_reg};
        qbit    = (shifted >= {1'b0, divisor_reg});
    end

    // Sequencing of the division steps.
    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            step_next    = '0;
            rem_next     = '0;
            quo_next     = req.dividend;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = qbit ? trial[fpa_pkg::CNT_W-1:0] : shifted[fpa_pkg::CNT_W-1:0];
            quo_next  = {quo_reg[fpa_pkg::SUM_W-2:0], qbit};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath needs none.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    // The mean never exceeds the largest period, so the low bits hold it.
    assign done     = done_reg;
    assign quotient = quo_reg[fpa_pkg::PERIOD_W-1:0];

endmodule

FILE: sv/frame_period_averager_fps_counter.sv
`timescale 1ns / 1ps
// Top level of the frame period averager and frame rate counter.
// Depends on fpa_pkg, fpa_history and fpa_divider.
//
// Usage:
//   The evt channel takes timestamp events (evt_valid / evt_stall). A start event
//   latches the timestamp and clears all counts; a frame event measures the period
//   since the last timestamp, filters it into a 16-entry moving window, counts the
//   frame toward a one-second window and updates the mean period.
//   Every event yields exactly one item on the res channel (res_valid / res_stall)
//   carrying the latched frame rate and the truncated mean period in ticks.
//   tick_frequency (ticks per second) is written through cfg_wr_en / cfg_wr_data;
//   the user must write it only while the block is idle, which the block does not
//   enforce. It resets to 10,000,000.
// Sequencing:
//   A start event goes from DIFF to DONE; a frame event takes three sequencer steps
//   (DIFF, FILT, WIN), then, with samples in the window, waits in DIV for the 36
//   quotient bits of the serial divider at one per cycle; DONE loads the output
//   register. Only one event is in flight: evt_stall stays high until that load.
// Reset and stall:
//   rst_n clears all counts, the timestamp and the output valid flag. When the
//   receiver stalls, the result waits in the output register while the next event
//   is accepted and worked on; that result is written only once the slot is free.

module frame_period_averager_fps_counter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          evt_valid,
    output logic                          evt_stall,
    input  fpa_pkg::evt_item_t            evt,
    output logic                          res_valid,
    input  logic                          res_stall,
    output fpa_pkg::res_item_t            res,
    input  logic                          cfg_wr_en,
    input  logic [fpa_pkg::PERIOD_W-1:0]  cfg_wr_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIFF = 3'd1;
    localparam logic [2:0] ST_FILT = 3'd2;
    localparam logic [2:0] ST_WIN  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    localparam logic [fpa_pkg::CNT_W-1:0]   FULL_COUNT = fpa_pkg::CNT_W'(fpa_pkg::HISTORY_DEPTH);
    localparam logic [fpa_pkg::HIST_AW-1:0] LAST_SLOT  =
        fpa_pkg::HIST_AW'(fpa_pkg::HISTORY_DEPTH - 1);

    logic [2:0]                      state_reg, state_next;
    fpa_pkg::evt_item_t              item_reg, item_next;
    logic [fpa_pkg::PERIOD_W-1:0]    tick_freq_reg, tick_freq_next;
    logic [fpa_pkg::TS_W-1:0]        last_ts_reg, last_ts_next;
    logic [fpa_pkg::PERIOD_W-1:0]    elapsed_reg, elapsed_next;
    logic [fpa_pkg::SUM_W-1:0]       sum_reg, sum_next;
    logic [fpa_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [fpa_pkg::HIST_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [fpa_pkg::RATE_W-1:0]      frames_reg, frames_next;
    logic [fpa_pkg::WTICK_W-1:0]     wticks_reg, wticks_next;
    logic [fpa_pkg::RATE_W-1:0]      rate_reg, rate_next;
    logic [fpa_pkg::PERIOD_W-1:0]    avg_reg, avg_next;
    logic                            res_valid_reg, res_valid_next;
    fpa_pkg::res_item_t              res_reg, res_next;

    logic                            evt_accept;
    logic                            res_load;
    logic [fpa_pkg::TS_W-1:0]        ts_diff;
    logic [fpa_pkg::PERIOD_W-1:0]    deviation;
    logic                            period_ok;
    logic                            hist_we;
    logic [fpa_pkg::PERIOD_W-1:0]    dropped;
    fpa_pkg::div_req_t               div_req;
    logic                            div_done;
    logic [fpa_pkg::PERIOD_W-1:0]    div_quotient;

    assign evt_accept = evt_valid && !evt_stall;
    assign evt_stall  = (state_reg != ST_IDLE);
    assign res_load   = (state_reg == ST_DONE) && (!res_valid_reg || !res_stall);

    // History window memory; the oldest entry sits at the write pointer.
    fpa_history u_history (
        .clk     (clk),
        .wr_en   (hist_we),
        .wr_addr (wr_ptr_reg),
        .wr_data (elapsed_reg),
        .rd_addr (wr_ptr_reg),
        .rd_data (dropped)
    );

    // Serial divider for the mean period.
    fpa_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Period measurement and filter against the current mean.
    always_comb
    begin
        ts_diff   = item_reg.timestamp - last_ts_reg;
        deviation = (elapsed_reg >= avg_reg) ? (elapsed_reg - avg_reg)
                                             : (avg_reg - elapsed_reg);
        period_ok = (deviation < tick_freq_reg);
        hist_we   = (state_reg == ST_FILT) && period_ok;
    end

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        tick_freq_next = cfg_wr_en ? cfg_wr_data : tick_freq_reg;
        last_ts_next   = last_ts_reg;
        elapsed_next   = elapsed_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        wr_ptr_next    = wr_ptr_reg;
        frames_next    = frames_reg;
        wticks_next    = wticks_reg;
        rate_next      = rate_reg;
        avg_next       = avg_reg;
        res_next       = res_reg;
        div_req        = '{start: 1'b0, dividend: sum_reg, divisor: count_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (evt_accept)
                begin
                    item_next  = evt;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                last_ts_next = item_reg.timestamp;
                if (item_reg.kind == fpa_pkg::KIND_START)
                begin
                    sum_next    = '0;
                    count_next  = '0;
                    frames_next = '0;
                    wticks_next = '0;
                    rate_next   = '0;
                    avg_next    = '0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    // Saturate the modular difference to the period width.
                    elapsed_next = (|ts_diff[fpa_pkg::TS_W-1:fpa_pkg::PERIOD_W])
                                   ? '1 : ts_diff[fpa_pkg::PERIOD_W-1:0];
                    state_next   = ST_FILT;
                end
            end
            ST_FILT:
            begin
                if (period_ok)
                begin
                    wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
                    if (count_reg < FULL_COUNT)
                    begin
                        count_next = count_reg + 1'b1;
                        sum_next   = sum_reg + fpa_pkg::SUM_W'(elapsed_reg);
                    end
                    else
                    begin
                        sum_next = sum_reg - fpa_pkg::SUM_W'(dropped)
                                 + fpa_pkg::SUM_W'(elapsed_reg);
                    end
                end
                if (frames_reg != '1)
                begin
                    frames_next = frames_reg + 1'b1;
                end
                wticks_next = wticks_reg + fpa_pkg::WTICK_W'(avg_reg);
                state_next  = ST_WIN;
            end
            ST_WIN:
            begin
                // More than one second of averaged frame time closes the rate window.
                if (wticks_reg > fpa_pkg::WTICK_W'(tick_freq_reg))
                begin
                    rate_next   = frames_reg;
                    frames_next = '0;
                    wticks_next = '0;
                end
                if (count_reg == '0)
                begin
                    avg_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    avg_next   = div_quotient;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_load)
                begin
                    res_next.frame_rate    = rate_reg;
                    res_next.average_ticks = avg_reg;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Output register handshake.
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else
        begin
            res_valid_next = res_valid_reg && res_stall;
        end
    end

    // Control and count state with asynchronous reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tick_freq_reg <= fpa_pkg::TICK_FREQ_RESET;
            last_ts_reg   <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            wr_ptr_reg    <= '0;
            frames_reg    <= '0;
            wticks_reg    <= '0;
            rate_reg      <= '0;
            avg_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_freq_reg <= tick_freq_next;
            last_ts_reg   <= last_ts_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            wr_ptr_reg    <= wr_ptr_next;
            frames_reg    <= frames_next;
            wticks_reg    <= wticks_next;
            rate_reg      <= rate_next;
            avg_reg       <= avg_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        elapsed_reg <= elapsed_next;
        res_reg     <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // The sample count never runs past the window depth.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_COUNT)
        else $error("sample count exceeds window depth");

    // The divider only ever runs with a nonzero sample count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (count_reg != '0))
        else $error("division by zero sample count");

    // A new result appears only after the sequencer finished an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result shown without a finished item");

    // A pending result is never overwritten while the receiver stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_stall) |=> $stable(res_reg))
        else $error("stalled result changed");

endmodule

FILE: sim/frame_rate_checker.sv
`timescale 1ns / 1ps
// Checker for the frame period averager: predicts frame rate and mean period per event
// item and compares them with the result items. Depends on fpa_pkg.

module frame_rate_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         evt_valid,
    input  logic                         evt_stall,
    input  fpa_pkg::evt_item_t           evt,
    input  logic                         res_valid,
    input  logic                         res_stall,
    input  fpa_pkg::res_item_t           res,
    input  logic                         cfg_wr_en,
    input  logic [fpa_pkg::PERIOD_W-1:0] cfg_wr_data,
    output int                           mismatches,
    output int                           in_flight
);

    // Predicted block state.
    logic [fpa_pkg::PERIOD_W-1:0] tick_hz;
    logic [fpa_pkg::TS_W-1:0]     prev_ts;
    logic [fpa_pkg::PERIOD_W-1:0] periods [fpa_pkg::HISTORY_DEPTH];
    logic [63:0]                  period_sum;
    int unsigned                  samples;
    logic [fpa_pkg::RATE_W-1:0]   frames_in_window;
    logic [63:0]                  mean_ticks_in_window;
    logic [fpa_pkg::RATE_W-1:0]   rate_hold;
    logic [fpa_pkg::PERIOD_W-1:0] mean_period;

    // Results still owed by the block, oldest first.
    fpa_pkg::res_item_t rate_and_mean_q[$];
    int                 bad_count;

    // Drop all counts, as a start event does.
    function automatic void clear_counts();
        period_sum           = '0;
        samples              = 0;
        frames_in_window     = '0;
        mean_ticks_in_window = '0;
        rate_hold            = '0;
        mean_period          = '0;
    endfunction

    // Advance the predicted state by one event and return the result it yields.
    function automatic fpa_pkg::res_item_t predict_rate_and_mean(fpa_pkg::evt_item_t e);
        logic [fpa_pkg::TS_W-1:0]     delta;
        logic [fpa_pkg::PERIOD_W-1:0] period;
        logic [fpa_pkg::PERIOD_W-1:0] old_mean;
        logic [fpa_pkg::PERIOD_W-1:0] deviation;
        fpa_pkg::res_item_t           r;
        if (e.kind == fpa_pkg::KIND_START)
        begin
            prev_ts = e.timestamp;
            clear_counts();
        end
        else
        begin
            delta    = e.timestamp - prev_ts;
            period   = (delta > 64'hFFFF_FFFF) ? '1 : delta[fpa_pkg::PERIOD_W-1:0];
            old_mean = mean_period;
            prev_ts  = e.timestamp;

            // Only periods within one second of the mean enter the window.
            deviation = (period >= old_mean) ? period - old_mean : old_mean - period;
            if (deviation < tick_hz)
            begin
                if (samples == fpa_pkg::HISTORY_DEPTH)
                begin
                    period_sum = period_sum - periods[fpa_pkg::HISTORY_DEPTH-1] + period;
                end
                else
                begin
                    samples++;
                    period_sum = period_sum + period;
                end
                for (int i = fpa_pkg::HISTORY_DEPTH - 1; i > 0; i--)
                begin
                    periods[i] = periods[i-1];
                end
                periods[0] = period;
            end

            // One-second window counts frames against the accumulated mean.
            if (frames_in_window != '1)
            begin
                frames_in_window++;
            end
            mean_ticks_in_window = mean_ticks_in_window + old_mean;
            if (mean_ticks_in_window > {32'b0, tick_hz})
            begin
                rate_hold            = frames_in_window;
                frames_in_window     = '0;
                mean_ticks_in_window = '0;
            end

            mean_period = (samples != 0)
                        ? fpa_pkg::PERIOD_W'(period_sum / 64'(samples)) : '0;
        end
        r.frame_rate    = rate_hold;
        r.average_ticks = mean_period;
        return r;
    endfunction

    // Count a failure; only the first ten are described.
    function automatic void report_mismatch(string what, fpa_pkg::res_item_t want,
                                            fpa_pkg::res_item_t got);
        bad_count++;
        if (bad_count <= 10)
        begin
            $display("%0t: %s: expected rate %0d mean %0d, got rate %0d mean %0d",
                     $realtime, what, want.frame_rate, want.average_ticks,
                     got.frame_rate, got.average_ticks);
        end
    endfunction

    // Results are checked before the event of the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_hz    = fpa_pkg::TICK_FREQ_RESET;
            prev_ts    = '0;
            clear_counts();
            rate_and_mean_q.delete();
            bad_count  = 0;
            mismatches <= 0;
            in_flight  <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (rate_and_mean_q.size() == 0)
                begin
                    report_mismatch("result with nothing pending", '0, res);
                end
                else
                begin
                    fpa_pkg::res_item_t want;
                    want = rate_and_mean_q.pop_front();
                    if (want.frame_rate !== res.frame_rate ||
                        want.average_ticks !== res.average_ticks)
                    begin
                        report_mismatch("result mismatch", want, res);
                    end
                end
            end
            if (evt_valid && !evt_stall)
            begin
                rate_and_mean_q.push_back(predict_rate_and_mean(evt));
            end
            if (cfg_wr_en)
            begin
                tick_hz = cfg_wr_data;
            end
            mismatches <= bad_count;
            in_flight  <= rate_and_mean_q.size();
        end
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for frame_period_averager_fps_counter: drives timestamp events and the
// tick frequency register, paces the result side and reports the verdict.
// Depends on fpa_pkg, the block itself and frame_rate_checker.

module tb_top;

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         evt_valid   = 1'b0;
    logic                         evt_stall;
    fpa_pkg::evt_item_t           evt         = '0;
    logic                         res_valid;
    logic                         res_stall   = 1'b0;
    fpa_pkg::res_item_t           res;
    logic                         cfg_wr_en   = 1'b0;
    logic [fpa_pkg::PERIOD_W-1:0] cfg_wr_data = '0;

    int          mismatches;
    int          in_flight;
    logic [63:0] now_ts = '0;
    bit          calm   = 1'b0;
    int unsigned rx_hold_left = 0;
    int unsigned rx_hold_draw;

    frame_period_averager_fps_counter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .evt_valid   (evt_valid),
        .evt_stall   (evt_stall),
        .evt         (evt),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    frame_rate_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .evt_valid   (evt_valid),
        .evt_stall   (evt_stall),
        .evt         (evt),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mismatches  (mismatches),
        .in_flight   (in_flight)
    );

    always #1 clk = ~clk;

    // Result side: after each accepted item, stall for a random number of cycles.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_stall    <= 1'b0;
            rx_hold_left <= 0;
        end
        else if (rx_hold_left != 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
            res_stall    <= (rx_hold_left > 1);
        end
        else if (res_valid && !res_stall)
        begin
            rx_hold_draw = calm ? 0 : $urandom_range(0, 3);
            rx_hold_left <= rx_hold_draw;
            res_stall    <= (rx_hold_draw != 0);
        end
    end

    // Offer one event item after a random gap and wait until it is taken.
    task automatic send_event(input logic kind, input logic [63:0] ts);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            evt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_valid     <= 1'b1;
        evt.kind      <= kind;
        evt.timestamp <= ts;
        @(posedge clk);
        while (evt_stall) @(posedge clk);
        now_ts = ts;
        if ($urandom_range(0, 29) == 0)
        begin
            calm = !calm;
        end
    endtask

    // Hold off the sender until every pending result has come back.
    task automatic wait_drained();
        evt_valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic set_tick_frequency(input logic [fpa_pkg::PERIOD_W-1:0] hz);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= hz;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly steady frame streams around a nominal period, mixed with restarts,
    // backward steps, huge jumps and arbitrary timestamps.
    task automatic run_phase(input logic [fpa_pkg::PERIOD_W-1:0] hz, input int count);
        longint unsigned base_period;
        longint unsigned spread;
        longint unsigned period_step;
        int unsigned     pick;
        wait_drained();
        set_tick_frequency(hz);
        if (hz >= 64)
        begin
            base_period = hz / $urandom_range(4, 24);
            spread      = hz / 16;
        end
        else
        begin
            base_period = $urandom_range(0, 4);
            spread      = 1;
        end
        for (int i = 0; i < count; i++)
        begin
            pick        = $urandom_range(0, 99);
            period_step = base_period + $urandom_range(0, 32'(2 * spread));
            period_step = (period_step > spread) ? period_step - spread : 0;
            if (pick < 80)
            begin
                send_event(fpa_pkg::KIND_FRAME, now_ts + period_step);
            end
            else if (pick < 86)
            begin
                send_event(fpa_pkg::KIND_START, now_ts + $urandom_range(0, 1000));
            end
            else if (pick < 90)
            begin
                send_event(fpa_pkg::KIND_FRAME, now_ts - $urandom_range(1, 5000));
            end
            else if (pick < 94)
            begin
                send_event(fpa_pkg::KIND_FRAME, now_ts + {$urandom, $urandom});
            end
            else if (pick < 98)
            begin
                send_event(1'($urandom_range(0, 1)), {$urandom, $urandom});
            end
            else
            begin
                send_event(fpa_pkg::KIND_FRAME, now_ts);
            end
            if ($urandom_range(0, 59) == 0)
            begin
                wait_drained();
            end
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset tick frequency of ten million.
        send_event(fpa_pkg::KIND_FRAME, 64'd5_000_000);
        send_event(fpa_pkg::KIND_START, 64'd0);
        for (int k = 1; k <= 12; k++)
        begin
            send_event(fpa_pkg::KIND_FRAME, now_ts + 64'd1_000_000);
        end
        // Zero period, a backward step and a jump to the top of the counter.
        send_event(fpa_pkg::KIND_FRAME, now_ts);
        send_event(fpa_pkg::KIND_FRAME, now_ts - 64'd1);
        send_event(fpa_pkg::KIND_FRAME, 64'hFFFF_FFFF_FFFF_FFFF);
        // Counter wrap-around, then both sides of the one-second filter edge.
        send_event(fpa_pkg::KIND_START, 64'hFFFF_FFFF_FFFF_FFF0);
        send_event(fpa_pkg::KIND_FRAME, 64'h0000_0000_0000_1000);
        send_event(fpa_pkg::KIND_FRAME, now_ts + 64'd4112 + 64'd10_000_000);
        send_event(fpa_pkg::KIND_FRAME, now_ts + 64'd4112 + 64'd9_999_999);
        // Largest period that does not saturate.
        send_event(fpa_pkg::KIND_FRAME, now_ts + 64'hFFFF_FFFF);
        send_event(fpa_pkg::KIND_FRAME, 64'h8000_0000_0000_0000);

        // Random part over several tick frequencies; zero follows the largest so
        // that a nonzero mean is carried into it.
        run_phase(32'd1, 60);
        run_phase(32'hFFFF_FFFF, 100);
        run_phase(32'd0, 50);
        run_phase(32'd1000, 120);
        run_phase($urandom, 100);
        run_phase($urandom_range(100, 200_000), 100);
        run_phase(32'd10_000_000, 100);

        wait_drained();
        if (mismatches == 0 && in_flight == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

    // Run limit.
    initial
    begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
